// ===== hdl/hpmv_pkg.sv =====
// Shared types and constants of the half-precision matrix-vector product.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hpmv_pkg;

	localparam int unsigned MaxColumns = 1024;
	localparam int unsigned MaxRows = 65536;
	localparam int unsigned ColW = $clog2(MaxColumns);
	localparam int unsigned RowW = $clog2(MaxRows);
	localparam int unsigned LenW = 11;
	localparam int unsigned CntW = 17;
	localparam int unsigned CfgW = 17;

	localparam logic [31:0] QNaN32 = 32'h7FC0_0000;

	// Register indexes of the configuration port.
	typedef enum logic {
		REG_ROW_LENGTH = 1'b0,
		REG_ROW_COUNT = 1'b1
	} reg_index_t;

	// Operation codes of an input request.
	typedef enum logic {
		OP_LOAD_VECTOR = 1'b0,
		OP_MATRIX_ELEM = 1'b1
	} opcode_t;

	// Control that travels with a matrix element down the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
		logic final_row;
		logic [RowW-1:0] row;
	} ctl_t;

endpackage

// ===== hdl/hpmv_if.sv =====
// Stream interfaces of the matrix-vector product: input requests and row results.
// Depends on hpmv_pkg.
`timescale 1ns / 1ps

interface hpmv_in_if import hpmv_pkg::*; ();
	logic valid;
	logic ready;
	logic opcode;
	logic [ColW-1:0] vector_index;
	logic [15:0] half_value;

	modport source (output valid, opcode, vector_index, half_value, input ready);
	modport sink (input valid, opcode, vector_index, half_value, output ready);
endinterface

interface hpmv_out_if import hpmv_pkg::*; ();
	logic valid;
	logic ready;
	logic [31:0] row_sum;
	logic [RowW-1:0] row_number;
	logic final_row;

	modport source (output valid, row_sum, row_number, final_row, input ready);
	modport sink (input valid, row_sum, row_number, final_row, output ready);
endinterface

// ===== hdl/hpmv_fp_mul.sv =====
// Registered binary16 x binary16 multiply with an exact binary32 result.
// Depends on hpmv_pkg.
`timescale 1ns / 1ps

module hpmv_fp_mul import hpmv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic enable,
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  ctl_t ctl_in,
	output logic [31:0] prod_s2,
	output ctl_t ctl_s2
);

	logic [4:0] ea, eb;
	logic [10:0] ma, mb;
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
	logic [21:0] p, norm;
	logic [4:0] lz;
	logic [8:0] e;
	logic [31:0] prod;

	// Unpack both operands; subnormals use exponent one without the hidden bit.
	always_comb begin
		ea = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
		eb = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
		ma = {a[14:10] != 5'd0, a[9:0]};
		mb = {b[14:10] != 5'd0, b[9:0]};
		a_nan = (&a[14:10]) && (a[9:0] != 10'd0);
		b_nan = (&b[14:10]) && (b[9:0] != 10'd0);
		a_inf = (&a[14:10]) && (a[9:0] == 10'd0);
		b_inf = (&b[14:10]) && (b[9:0] == 10'd0);
		a_zero = a[14:0] == 15'd0;
		b_zero = b[14:0] == 15'd0;
		sgn = a[15] ^ b[15];
	end

	// The significand product fits in 22 bits and always yields a normal binary32.
	always_comb begin
		p = 22'(ma * mb);
		lz = 5'd0;
		for (int i = 0; i < 22; i++) begin
			if (p[i]) begin
				lz = 5'(21 - i);
			end
		end
		norm = p << lz;
		e = 9'(ea) + 9'(eb) + 9'd98 - 9'(lz);
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
			prod = QNaN32;
		end else if (a_inf || b_inf) begin
			prod = {sgn, 8'hFF, 23'd0};
		end else if (p == 22'd0) begin
			prod = {sgn, 31'd0};
		end else begin
			prod = {sgn, e[7:0], norm[20:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (enable) begin
			ctl_s2 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (enable) begin
			prod_s2 <= prod;
		end
	end

endmodule

// ===== hdl/hpmv_fp_add.sv =====
// Binary32 adder with round-to-nearest-even and a canonical quiet NaN.
// Depends on hpmv_pkg.
`timescale 1ns / 1ps

module hpmv_fp_add import hpmv_pkg::*; (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap, sgn;
	logic [31:0] big, sml;
	logic [7:0] xe, ye, d;
	logic [26:0] xm, ym, ysh, n;
	logic st, rnd;
	logic [27:0] s;
	logic [8:0] e, lim;
	logic [4:0] lz, sh;
	logic [24:0] m;

	always_comb begin
		a_nan = (&a[30:23]) && (a[22:0] != 23'd0);
		b_nan = (&b[30:23]) && (b[22:0] != 23'd0);
		a_inf = (&a[30:23]) && (a[22:0] == 23'd0);
		b_inf = (&b[30:23]) && (b[22:0] == 23'd0);
		a_zero = a[30:0] == 31'd0;
		b_zero = b[30:0] == 31'd0;

		// Order operands by magnitude and align the smaller one with sticky.
		swap = b[30:0] > a[30:0];
		big = swap ? b : a;
		sml = swap ? a : b;
		sgn = big[31];
		xe = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		ye = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		xm = {big[30:23] != 8'd0, big[22:0], 3'b000};
		ym = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
		d = xe - ye;
		if (d >= 8'd27) begin
			ysh = 27'd0;
			st = |ym;
		end else begin
			ysh = ym >> d;
			st = |(ym & ((27'd1 << d) - 27'd1));
		end
		ysh[0] = ysh[0] | st;

		if (a[31] == b[31]) begin
			s = {1'b0, xm} + {1'b0, ysh};
		end else begin
			s = {1'b0, xm} - {1'b0, ysh};
		end

		// Normalize: one step right on carry, else left down to the subnormal limit.
		e = {1'b0, xe};
		lz = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (s[i]) begin
				lz = 5'(26 - i);
			end
		end
		lim = e - 9'd1;
		sh = (9'(lz) < lim) ? lz : lim[4:0];
		if (s[27]) begin
			n = {s[27:2], s[1] | s[0]};
			e = e + 9'd1;
		end else begin
			n = s[26:0] << sh;
			e = e - 9'(sh);
		end

		// Round to nearest, ties to even.
		rnd = n[2] & (n[1] | n[0] | n[3]);
		m = {1'b0, n[26:3]} + 25'(rnd);
		if (m[24]) begin
			m = m >> 1;
			e = e + 9'd1;
		end

		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
			y = QNaN32;
		end else if (a_inf) begin
			y = a;
		end else if (b_inf) begin
			y = b;
		end else if (a_zero && b_zero) begin
			y = {a[31] & b[31], 31'd0};
		end else if (a_zero) begin
			y = b;
		end else if (b_zero) begin
			y = a;
		end else if (s == 28'd0) begin
			y = 32'd0;
		end else if (e >= 9'd255) begin
			y = {sgn, 8'hFF, 23'd0};
		end else begin
			y = {sgn, m[23] ? e[7:0] : 8'd0, m[22:0]};
		end
	end

endmodule

// ===== hdl/half_precision_matrix_vector_product.sv =====
// Top level of the half-precision matrix-vector product with binary32 accumulation.
// Depends on hpmv_pkg, hpmv_if, hpmv_fp_mul and hpmv_fp_add.
`timescale 1ns / 1ps

// Computes y = A x. Requests with opcode 0 write a binary16 vector entry; requests
// with opcode 1 stream matrix elements in row-major order. One request is taken
// every cycle unless the input stalls. A matrix element passes three stages: the
// vector store read (one synchronous RAM, 1024 x 16), the exact multiply, and the
// binary32 add into the accumulator, which closes on itself each cycle. The row sum
// of a row's last element goes through the store-read and multiply registers and
// waits in an output register; the input only stalls when a second row sum reaches
// the add stage while the first is still held.
module half_precision_matrix_vector_product import hpmv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	hpmv_in_if.sink items,
	hpmv_out_if.source results
);

	logic [LenW-1:0] row_length_q, k_eff;
	logic [CntW-1:0] row_count_q, m_eff;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic [15:0] vec_mem [MaxColumns];
	logic [15:0] vec_rd_s1, half_s1;
	ctl_t ctl_s1, ctl_s2, ctl_new;
	logic [31:0] prod_s2, acc_q, sum, out_sum_q;
	logic [RowW-1:0] out_row_q;
	logic out_final_q, out_v_q;
	logic stall, accept, mat_accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= LenW'(1);
			row_count_q <= CntW'(1);
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_ROW_LENGTH: row_length_q <= cfg_data[LenW-1:0];
				REG_ROW_COUNT: row_count_q <= cfg_data[CntW-1:0];
				default: ;
			endcase
		end
	end

	// Effective lengths: zero acts as one, values above the maximum saturate.
	always_comb begin
		if (row_length_q == '0) begin
			k_eff = LenW'(1);
		end else if (row_length_q > LenW'(MaxColumns)) begin
			k_eff = LenW'(MaxColumns);
		end else begin
			k_eff = row_length_q;
		end
		if (row_count_q == '0) begin
			m_eff = CntW'(1);
		end else if (row_count_q > CntW'(MaxRows)) begin
			m_eff = CntW'(MaxRows);
		end else begin
			m_eff = row_count_q;
		end
	end

	// Stall only while a row sum is held and another one is due at the add stage.
	assign stall = out_v_q && !results.ready && ctl_s2.valid && ctl_s2.last;
	assign items.ready = !stall;
	assign accept = items.valid && items.ready;
	assign mat_accept = accept && (opcode_t'(items.opcode) == OP_MATRIX_ELEM);

	// Row and column position of the incoming matrix element.
	always_comb begin
		ctl_new.valid = mat_accept;
		ctl_new.last = ({1'b0, col_q} + LenW'(1)) >= k_eff;
		ctl_new.final_row = ({1'b0, row_q} + CntW'(1)) >= m_eff;
		ctl_new.row = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (mat_accept) begin
			if (ctl_new.last) begin
				col_q <= '0;
				row_q <= ctl_new.final_row ? '0 : row_q + RowW'(1);
			end else begin
				col_q <= col_q + ColW'(1);
			end
		end
	end

	// Vector store: written by load requests, read at the current column.
	always_ff @(posedge clk) begin
		if (accept && (opcode_t'(items.opcode) == OP_LOAD_VECTOR)) begin
			vec_mem[items.vector_index] <= items.half_value;
		end
		if (mat_accept) begin
			vec_rd_s1 <= vec_mem[col_q];
			half_s1 <= items.half_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (!stall) begin
			ctl_s1 <= ctl_new;
		end
	end

	hpmv_fp_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.enable(!stall),
		.a(half_s1),
		.b(vec_rd_s1),
		.ctl_in(ctl_s1),
		.prod_s2(prod_s2),
		.ctl_s2(ctl_s2)
	);

	hpmv_fp_add u_add (
		.a(acc_q),
		.b(prod_s2),
		.y(sum)
	);

	// Accumulator and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (ctl_s2.valid && ctl_s2.last && !stall) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			if (ctl_s2.valid && !stall) begin
				acc_q <= ctl_s2.last ? '0 : sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && ctl_s2.last && !stall) begin
			out_sum_q <= sum;
			out_row_q <= ctl_s2.row;
			out_final_q <= ctl_s2.final_row;
		end
	end

	assign results.valid = out_v_q;
	assign results.row_sum = out_sum_q;
	assign results.row_number = out_row_q;
	assign results.final_row = out_final_q;

endmodule

// ===== tb/tb_half_precision_matrix_vector_product.sv =====
// Testbench of half_precision_matrix_vector_product: directed and random request streams,
// checked against a bit-exact binary16 x binary16 -> binary32 accumulate predictor.
// Depends on hpmv_pkg, hpmv_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_half_precision_matrix_vector_product;
	import hpmv_pkg::*;

	localparam int unsigned StallLimit = 5000;
	localparam int unsigned TargetItems = 1550;

	typedef struct {
		logic [31:0] row_sum;
		logic [RowW-1:0] row_number;
		logic final_row;
	} row_result_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic cfg_index;
	logic [CfgW-1:0] cfg_data;

	hpmv_in_if items_if ();
	hpmv_out_if results_if ();

	half_precision_matrix_vector_product DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.items(items_if),
		.results(results_if)
	);

	// Predictor state: a copy of the vector store, the accumulator, counters and registers.
	logic [15:0] vec_mem [MaxColumns];
	bit vec_written [MaxColumns];
	logic [31:0] acc_bits;
	int unsigned col_pos;
	int unsigned row_pos;
	logic [LenW-1:0] len_reg;
	logic [CntW-1:0] cnt_reg;

	row_result_t pending_rows[$];
	int unsigned errors;
	int unsigned sent_items;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned stall_cycles;

	// Clock.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Rounds the exact value mag * 2^lsb_exp to binary32, nearest even.
	function automatic logic [31:0] pack_single(bit sgn, logic [319:0] mag, int lsb_exp);
		int top;
		int t;
		int sh;
		logic [319:0] r;
		logic [319:0] rem;
		logic [319:0] halfway;
		int biased;
		top = 0;
		for (int i = 0; i < 320; i++) begin
			if (mag[i]) top = i;
		end
		t = top + lsb_exp - 23;
		if (t < -149) t = -149;
		sh = t - lsb_exp;
		if (sh > 0) begin
			r = mag >> sh;
			rem = mag & ((320'd1 << sh) - 320'd1);
			halfway = 320'd1 << (sh - 1);
			if (rem > halfway || (rem == halfway && r[0])) r = r + 320'd1;
		end else begin
			r = mag << (-sh);
		end
		if (r[24]) begin
			r = r >> 1;
			t++;
		end
		if (!r[23]) return {sgn, 8'd0, r[22:0]};
		biased = t + 150;
		if (biased >= 255) return {sgn, 8'hFF, 23'd0};
		return {sgn, biased[7:0], r[22:0]};
	endfunction

	// Exact product of two binary16 values as binary32.
	function automatic logic [31:0] half_product(logic [15:0] a, logic [15:0] x);
		bit s;
		bit a_nan;
		bit x_nan;
		bit a_inf;
		bit x_inf;
		bit a_zero;
		bit x_zero;
		logic [319:0] ma;
		logic [319:0] mx;
		int ea;
		int ex;
		s = a[15] ^ x[15];
		a_nan = a[14:10] == 5'h1F && a[9:0] != 0;
		x_nan = x[14:10] == 5'h1F && x[9:0] != 0;
		a_inf = a[14:10] == 5'h1F && a[9:0] == 0;
		x_inf = x[14:10] == 5'h1F && x[9:0] == 0;
		a_zero = a[14:0] == 0;
		x_zero = x[14:0] == 0;
		if (a_nan || x_nan || (a_inf && x_zero) || (x_inf && a_zero)) return QNaN32;
		if (a_inf || x_inf) return {s, 8'hFF, 23'd0};
		if (a_zero || x_zero) return {s, 31'd0};
		ma = (a[14:10] == 0) ? a[9:0] : {1'b1, a[9:0]};
		ea = (a[14:10] == 0) ? -24 : int'(a[14:10]) - 25;
		mx = (x[14:10] == 0) ? x[9:0] : {1'b1, x[9:0]};
		ex = (x[14:10] == 0) ? -24 : int'(x[14:10]) - 25;
		return pack_single(s, ma * mx, ea + ex);
	endfunction

	// Binary32 sum, nearest even, any NaN made canonical.
	function automatic logic [31:0] single_sum(logic [31:0] a, logic [31:0] b);
		bit a_inf;
		bit b_inf;
		logic [319:0] ma;
		logic [319:0] mb;
		int ea;
		int eb;
		int emin;
		if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
			return QNaN32;
		a_inf = a[30:23] == 8'hFF;
		b_inf = b[30:23] == 8'hFF;
		if (a_inf && b_inf && a[31] != b[31]) return QNaN32;
		if (a_inf) return a;
		if (b_inf) return b;
		if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
		if (a[30:0] == 0) return b;
		if (b[30:0] == 0) return a;
		ma = (a[30:23] == 0) ? a[22:0] : {1'b1, a[22:0]};
		ea = (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
		mb = (b[30:23] == 0) ? b[22:0] : {1'b1, b[22:0]};
		eb = (b[30:23] == 0) ? -149 : int'(b[30:23]) - 150;
		emin = (ea < eb) ? ea : eb;
		ma = ma << (ea - emin);
		mb = mb << (eb - emin);
		if (a[31] == b[31]) return pack_single(a[31], ma + mb, emin);
		if (ma > mb) return pack_single(a[31], ma - mb, emin);
		if (mb > ma) return pack_single(b[31], mb - ma, emin);
		return 32'd0;
	endfunction

	// Advances the predictor by one accepted request.
	task automatic predict_request(opcode_t op, logic [ColW-1:0] idx, logic [15:0] val);
		int unsigned eff_len;
		int unsigned eff_cnt;
		bit is_final;
		row_result_t r;
		if (op == OP_LOAD_VECTOR) begin
			vec_mem[idx] = val;
			vec_written[idx] = 1'b1;
			return;
		end
		eff_len = (len_reg == 0) ? 1 : (len_reg > MaxColumns) ? MaxColumns : len_reg;
		eff_cnt = (cnt_reg == 0) ? 1 : (cnt_reg > MaxRows) ? MaxRows : cnt_reg;
		acc_bits = single_sum(acc_bits, half_product(val, vec_mem[col_pos]));
		if (col_pos + 1 < eff_len) begin
			col_pos = (col_pos + 1) % MaxColumns;
			return;
		end
		is_final = row_pos + 1 >= eff_cnt;
		r.row_sum = acc_bits;
		r.row_number = row_pos[RowW-1:0];
		r.final_row = is_final;
		pending_rows.push_back(r);
		acc_bits = 32'd0;
		col_pos = 0;
		row_pos = is_final ? 0 : (row_pos + 1) % MaxRows;
	endtask

	// Sends one request; valid stays high afterwards so back-to-back requests need no gap.
	task automatic send_request(opcode_t op, logic [ColW-1:0] idx, logic [15:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.opcode <= op;
		items_if.vector_index <= idx;
		items_if.half_value <= val;
		do @(posedge clk); while (!items_if.ready);
		predict_request(op, idx, val);
		sent_items++;
	endtask

	// A matrix element; the vector entry of its column is loaded first if it never was.
	task automatic send_matrix(logic [15:0] val);
		if (!vec_written[col_pos])
			send_request(OP_LOAD_VECTOR, col_pos[ColW-1:0], 16'($urandom_range(16'hFFFF)));
		send_request(OP_MATRIX_ELEM, ColW'($urandom_range(MaxColumns - 1)), val);
	endtask

	// Stops sending and waits until every row result has come out.
	task automatic drain_results();
		items_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_rows.size() != 0) @(posedge clk);
	endtask

	// Register write, done only while the block is idle.
	task automatic write_register(reg_index_t idx, int unsigned value);
		drain_results();
		repeat (8) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CfgW-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_ROW_LENGTH) len_reg = value[LenW-1:0];
		else cnt_reg = value[CntW-1:0];
	endtask

	// Binary16 operand mix: normal magnitudes, raw patterns and special values.
	function automatic logic [15:0] pick_half();
		logic [15:0] specials [12] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
			16'hFC01, 16'h0001, 16'h83FF, 16'h0400, 16'h7BFF, 16'hFBFF, 16'h3C00};
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return {1'($urandom_range(1)), 5'($urandom_range(20, 8)),
			10'($urandom_range(1023))};
		if (r < 88) return 16'($urandom_range(16'hFFFF));
		return specials[$urandom_range(11)];
	endfunction

	// Extremes of both registers, every special value, and a row cut short by a
	// shorter row length written in the middle of the row.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(REG_ROW_LENGTH, 4);
		write_register(REG_ROW_COUNT, 2);
		send_request(OP_LOAD_VECTOR, 0, 16'h3C00);
		send_request(OP_LOAD_VECTOR, 1, 16'h0001);
		send_request(OP_LOAD_VECTOR, 2, 16'h7BFF);
		send_request(OP_LOAD_VECTOR, 3, 16'h8000);
		send_request(OP_LOAD_VECTOR, MaxColumns - 1, 16'h3555);
		send_matrix(16'h3C00);
		send_matrix(16'h7BFF);
		send_matrix(16'hFBFF);
		send_matrix(16'h0001);
		send_matrix(16'h7C00);
		send_matrix(16'h0000);
		send_matrix(16'h3C00);
		send_matrix(16'hFFFF);
		send_matrix(16'h8001);
		send_matrix(16'hFC00);
		send_matrix(16'h3C00);
		send_matrix(16'h7C00);
		// Zero in both registers acts as one.
		write_register(REG_ROW_LENGTH, 0);
		write_register(REG_ROW_COUNT, 0);
		send_matrix(16'h4000);
		// Values above the maximum saturate; then the row is ended early.
		write_register(REG_ROW_LENGTH, 2047);
		write_register(REG_ROW_COUNT, 131071);
		send_matrix(16'h3C00);
		write_register(REG_ROW_LENGTH, 1);
		send_matrix(16'hBC00);
		write_register(REG_ROW_COUNT, MaxRows);
		send_matrix(16'h0400);
		drain_results();
	endtask

	// Random matrices with random shapes, mostly well formed, with stray vector
	// loads, mid-row register changes and a full pause now and then.
	task automatic test_random(int unsigned n_items, int unsigned s_pct, int unsigned r_pct);
		int unsigned stop_at;
		int unsigned r;
		int unsigned eff_len;
		int unsigned n_rows;
		bit broken;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			r = $urandom_range(99);
			write_register(REG_ROW_LENGTH, (r < 3) ? 0 : (r < 60) ? $urandom_range(6, 1) :
				(r < 90) ? $urandom_range(24, 7) : $urandom_range(64, 25));
			write_register(REG_ROW_COUNT, $urandom_range(5));
			eff_len = (len_reg == 0) ? 1 : len_reg;
			for (int i = 0; i < eff_len; i++) begin
				if ($urandom_range(99) < 70) send_request(OP_LOAD_VECTOR, ColW'(i), pick_half());
			end
			repeat ($urandom_range(2))
				send_request(OP_LOAD_VECTOR, ColW'($urandom_range(MaxColumns - 1)),
					pick_half());
			n_rows = ((cnt_reg == 0) ? 1 : cnt_reg) + $urandom_range(1);
			broken = 1'b0;
			for (int i = 0; i < n_rows * eff_len && !broken; i++) begin
				r = $urandom_range(99);
				if (r < 4)
					send_request(OP_LOAD_VECTOR, ColW'($urandom_range(MaxColumns - 1)),
						pick_half());
				else if (r < 7)
					drain_results();
				else if (r < 9) begin
					write_register(REG_ROW_LENGTH, $urandom_range(12));
					broken = 1'b1;
				end
				send_matrix(pick_half());
			end
		end
		drain_results();
	endtask

	// Result readiness, idling at the rate of the current phase.
	always @(posedge clk) begin
		results_if.ready <= $urandom_range(99) >= recv_idle_pct;
	end

	// Compares every row result with the oldest expected one.
	always @(posedge clk) begin : check_rows
		row_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected row result sum %h row %0d final %b", $time,
					results_if.row_sum, results_if.row_number, results_if.final_row);
				errors++;
			end else begin
				want = pending_rows.pop_front();
				if (results_if.row_sum !== want.row_sum) begin
					$display("%0t: row_sum expected %h actual %h", $time, want.row_sum,
						results_if.row_sum);
					errors++;
				end
				if (results_if.row_number !== want.row_number) begin
					$display("%0t: row_number expected %0d actual %0d", $time,
						want.row_number, results_if.row_number);
					errors++;
				end
				if (results_if.final_row !== want.final_row) begin
					$display("%0t: final_row expected %b actual %b", $time, want.final_row,
						results_if.final_row);
					errors++;
				end
			end
		end
	end

	// Ends the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= StallLimit) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_ROW_LENGTH;
		cfg_data = '0;
		items_if.valid = 1'b0;
		items_if.opcode = OP_LOAD_VECTOR;
		items_if.vector_index = '0;
		items_if.half_value = '0;
		results_if.ready = 1'b0;
		stall_cycles = 0;
		errors = 0;
		sent_items = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		acc_bits = 32'd0;
		col_pos = 0;
		row_pos = 0;
		len_reg = 1;
		cnt_reg = 1;
		for (int i = 0; i < MaxColumns; i++) begin
			vec_mem[i] = 16'd0;
			vec_written[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(TargetItems / 3, 6, 81);
		test_random(TargetItems / 3, 81, 6);
		test_random(TargetItems / 3, 0, 0);
		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_rows.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
